/* rtl/core/mntp_pkg.sv */
// ----------------------------------------------------------------------------
// Melody note token parser package
// Shared constants, types and the note frequency table.
// ----------------------------------------------------------------------------
package mntp_pkg;

    localparam int MaxDots      = 7;
    localparam int DivisorWidth = 16;
    localparam int DotWidth     = 3;
    localparam int FreqWidth    = 21;
    localparam int DurWidth     = 32;

    // Numerator 240000000 * 3^7 fits in 41 bits; denominator 1000*65535*128 in 33.
    localparam int NumWidth = 42;
    localparam int DenWidth = 34;
    localparam int QuoWidth = 42;
    localparam int CntWidth = 6;

    localparam logic [NumWidth-1:0] BaseNum = NumWidth'(240000000);

    localparam logic [1:0] StOk        = 2'd0;
    localparam logic [1:0] StBadLetter = 2'd1;
    localparam logic [1:0] StZeroDiv   = 2'd2;
    localparam logic [1:0] StOctave    = 2'd3;

    localparam logic [1:0] CfgTempo   = 2'd0;
    localparam logic [1:0] CfgDivisor = 2'd1;
    localparam logic [1:0] CfgOctave  = 2'd2;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_DIGITS = 6'b000010,
        PH_NOTE   = 6'b000100,
        PH_SHARP  = 6'b001000,
        PH_TAIL   = 6'b010000,
        PH_BAD    = 6'b100000
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SCL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_seq;

    // Equal-tempered centihertz; octave 1..9, or 1..8 when sharp selects the raised tone.
    function automatic logic [FreqWidth-1:0] note_freq(input logic [3:0] oct,
                                                       input logic [2:0] idx,
                                                       input logic sharp);
        logic [FreqWidth-1:0] f;
        f = '0;
        if (!sharp) begin
            unique case ({oct, idx})
                {4'd1,3'd0}: f = 21'd3270;    {4'd1,3'd1}: f = 21'd3671;
                {4'd1,3'd2}: f = 21'd4120;    {4'd1,3'd3}: f = 21'd4365;
                {4'd1,3'd4}: f = 21'd4900;    {4'd1,3'd5}: f = 21'd5500;
                {4'd1,3'd6}: f = 21'd6174;
                {4'd2,3'd0}: f = 21'd6541;    {4'd2,3'd1}: f = 21'd7342;
                {4'd2,3'd2}: f = 21'd8241;    {4'd2,3'd3}: f = 21'd8731;
                {4'd2,3'd4}: f = 21'd9800;    {4'd2,3'd5}: f = 21'd11000;
                {4'd2,3'd6}: f = 21'd12347;
                {4'd3,3'd0}: f = 21'd13081;   {4'd3,3'd1}: f = 21'd14683;
                {4'd3,3'd2}: f = 21'd16481;   {4'd3,3'd3}: f = 21'd17461;
                {4'd3,3'd4}: f = 21'd19600;   {4'd3,3'd5}: f = 21'd22000;
                {4'd3,3'd6}: f = 21'd24694;
                {4'd4,3'd0}: f = 21'd26163;   {4'd4,3'd1}: f = 21'd29366;
                {4'd4,3'd2}: f = 21'd32963;   {4'd4,3'd3}: f = 21'd34923;
                {4'd4,3'd4}: f = 21'd39200;   {4'd4,3'd5}: f = 21'd44000;
                {4'd4,3'd6}: f = 21'd49388;
                {4'd5,3'd0}: f = 21'd52325;   {4'd5,3'd1}: f = 21'd58733;
                {4'd5,3'd2}: f = 21'd65925;   {4'd5,3'd3}: f = 21'd69846;
                {4'd5,3'd4}: f = 21'd78399;   {4'd5,3'd5}: f = 21'd88000;
                {4'd5,3'd6}: f = 21'd98777;
                {4'd6,3'd0}: f = 21'd104650;  {4'd6,3'd1}: f = 21'd117466;
                {4'd6,3'd2}: f = 21'd131851;  {4'd6,3'd3}: f = 21'd139691;
                {4'd6,3'd4}: f = 21'd156798;  {4'd6,3'd5}: f = 21'd176000;
                {4'd6,3'd6}: f = 21'd197553;
                {4'd7,3'd0}: f = 21'd209300;  {4'd7,3'd1}: f = 21'd234932;
                {4'd7,3'd2}: f = 21'd263702;  {4'd7,3'd3}: f = 21'd279383;
                {4'd7,3'd4}: f = 21'd313596;  {4'd7,3'd5}: f = 21'd352000;
                {4'd7,3'd6}: f = 21'd395107;
                {4'd8,3'd0}: f = 21'd418601;  {4'd8,3'd1}: f = 21'd469863;
                {4'd8,3'd2}: f = 21'd527404;  {4'd8,3'd3}: f = 21'd558765;
                {4'd8,3'd4}: f = 21'd627193;  {4'd8,3'd5}: f = 21'd704000;
                {4'd8,3'd6}: f = 21'd790213;
                {4'd9,3'd0}: f = 21'd837202;  {4'd9,3'd1}: f = 21'd939727;
                {4'd9,3'd2}: f = 21'd1054808; {4'd9,3'd3}: f = 21'd1117530;
                {4'd9,3'd4}: f = 21'd1254385; {4'd9,3'd5}: f = 21'd1408000;
                {4'd9,3'd6}: f = 21'd1580427;
                default: f = '0;
            endcase
        end else begin
            unique case ({oct, idx})
                {4'd1,3'd0}: f = 21'd3465;    {4'd1,3'd1}: f = 21'd3889;
                {4'd1,3'd2}: f = 21'd4365;    {4'd1,3'd3}: f = 21'd4625;
                {4'd1,3'd4}: f = 21'd5191;    {4'd1,3'd5}: f = 21'd5827;
                {4'd1,3'd6}: f = 21'd6541;
                {4'd2,3'd0}: f = 21'd6930;    {4'd2,3'd1}: f = 21'd7778;
                {4'd2,3'd2}: f = 21'd8731;    {4'd2,3'd3}: f = 21'd9250;
                {4'd2,3'd4}: f = 21'd10383;   {4'd2,3'd5}: f = 21'd11654;
                {4'd2,3'd6}: f = 21'd13081;
                {4'd3,3'd0}: f = 21'd13859;   {4'd3,3'd1}: f = 21'd15556;
                {4'd3,3'd2}: f = 21'd17461;   {4'd3,3'd3}: f = 21'd18500;
                {4'd3,3'd4}: f = 21'd20765;   {4'd3,3'd5}: f = 21'd23308;
                {4'd3,3'd6}: f = 21'd26163;
                {4'd4,3'd0}: f = 21'd27718;   {4'd4,3'd1}: f = 21'd31113;
                {4'd4,3'd2}: f = 21'd34923;   {4'd4,3'd3}: f = 21'd36999;
                {4'd4,3'd4}: f = 21'd41530;   {4'd4,3'd5}: f = 21'd46616;
                {4'd4,3'd6}: f = 21'd52325;
                {4'd5,3'd0}: f = 21'd55437;   {4'd5,3'd1}: f = 21'd62225;
                {4'd5,3'd2}: f = 21'd69846;   {4'd5,3'd3}: f = 21'd73999;
                {4'd5,3'd4}: f = 21'd83061;   {4'd5,3'd5}: f = 21'd93233;
                {4'd5,3'd6}: f = 21'd104650;
                {4'd6,3'd0}: f = 21'd110873;  {4'd6,3'd1}: f = 21'd124451;
                {4'd6,3'd2}: f = 21'd139691;  {4'd6,3'd3}: f = 21'd147998;
                {4'd6,3'd4}: f = 21'd166122;  {4'd6,3'd5}: f = 21'd186466;
                {4'd6,3'd6}: f = 21'd209300;
                {4'd7,3'd0}: f = 21'd221746;  {4'd7,3'd1}: f = 21'd248902;
                {4'd7,3'd2}: f = 21'd279383;  {4'd7,3'd3}: f = 21'd295996;
                {4'd7,3'd4}: f = 21'd332244;  {4'd7,3'd5}: f = 21'd372931;
                {4'd7,3'd6}: f = 21'd418601;
                {4'd8,3'd0}: f = 21'd443492;  {4'd8,3'd1}: f = 21'd497803;
                {4'd8,3'd2}: f = 21'd558765;  {4'd8,3'd3}: f = 21'd591991;
                {4'd8,3'd4}: f = 21'd664488;  {4'd8,3'd5}: f = 21'd745862;
                {4'd8,3'd6}: f = 21'd837202;
                default: f = '0;
            endcase
        end
        return f;
    endfunction

endpackage

/* rtl/core/melody_note_token_parser_core.sv */
// Timing: a character that closes no note updates the token state without stalling the
// input. A comma or the final character starts the duration unit: a multiply state,
// one scaling step per dot, a bit-serial division over the numerator bits and a load into
// the output register; a zero denominator skips the scaling and the division.
// No character is accepted while the unit is busy, until the note enters the output register.
// Reset is synchronous, active low, and restores the configuration, the sequencer, the output valid and an empty token.
// ----------------------------------------------------------------------------
// Melody note token parser core
// Parses melody text character by character and emits one note per token.
// ----------------------------------------------------------------------------
module melody_note_token_parser_core
    import mntp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_char_code,
    input  logic                    i_end_of_text,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [FreqWidth-1:0]    o_freq_centihertz,
    output logic [DurWidth-1:0]     o_duration_us,
    output logic [3:0]              o_octave_used,
    output logic [1:0]              o_status,
    output logic                    o_last_note
);

    // Configuration registers.
    logic [9:0]  r_tempo;
    logic [15:0] r_def_div;
    logic [3:0]  r_def_oct;

    // Token parse state.
    t_phase                  r_phase;
    logic [DivisorWidth-1:0] r_div_acc;
    logic                    r_div_seen;
    logic [2:0]              r_note_idx;
    logic                    r_sharp;
    logic [3:0]              r_oct;
    logic [DotWidth-1:0]     r_dots;

    // Sequencer and the shared arithmetic datapath.
    t_seq                r_seq;
    logic [NumWidth-1:0] r_num;
    logic [DenWidth-1:0] r_den;
    logic [NumWidth-1:0] r_rem;
    logic [QuoWidth-1:0] r_quo;
    logic [CntWidth-1:0] r_cnt;
    logic [DotWidth-1:0] r_dot_left;
    logic                r_zero_den;

    logic [FreqWidth-1:0] r_freq;
    logic [3:0]           r_oct_out;
    logic [1:0]           r_status;
    logic                 r_last;
    logic [DivisorWidth-1:0] r_div_use;

    // Output register; a finished note waits here so characters keep flowing.
    logic                 r_out_valid;
    logic [FreqWidth-1:0] r_out_freq;
    logic [DurWidth-1:0]  r_out_dur;
    logic [3:0]           r_out_oct;
    logic [1:0]           r_out_status;
    logic                 r_out_last;
    logic                 out_load;
    logic [DurWidth-1:0]  dur_sat;

    logic accept_in;
    logic [7:0] c;
    logic is_blank, is_digit, is_comma;
    logic [2:0] letter;
    logic letter_ok;
    logic [3:0] digit;
    logic [DivisorWidth+3:0] acc_next;
    logic emit_now;

    assign o_stall   = (r_seq != S_IDLE);
    assign accept_in = i_valid && !o_stall;
    assign c         = i_char_code;
    assign is_blank  = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    assign is_digit  = (c >= 8'd48 && c <= 8'd57);
    assign is_comma  = (c == 8'd44);
    assign digit     = c[3:0];
    assign emit_now  = accept_in && (is_comma || i_end_of_text);
    assign acc_next  = (DivisorWidth+4)'(r_div_acc) * (DivisorWidth+4)'(10) +
                       (DivisorWidth+4)'(digit);

    always_comb begin
        letter_ok = 1'b1;
        letter    = 3'd0;
        unique case (c)
            8'd67:   letter = 3'd0;
            8'd68:   letter = 3'd1;
            8'd69:   letter = 3'd2;
            8'd70:   letter = 3'd3;
            8'd71:   letter = 3'd4;
            8'd65:   letter = 3'd5;
            8'd66:   letter = 3'd6;
            default: letter_ok = 1'b0;
        endcase
    end

    // Next token state after this character, before the note is emitted.
    t_phase               n_phase;
    logic [DivisorWidth-1:0] n_div_acc;
    logic                 n_div_seen;
    logic [2:0]           n_note_idx;
    logic                 n_sharp;
    logic [3:0]           n_oct;
    logic [DotWidth-1:0]  n_dots;

    always_comb begin
        n_phase    = r_phase;
        n_div_acc  = r_div_acc;
        n_div_seen = r_div_seen;
        n_note_idx = r_note_idx;
        n_sharp    = r_sharp;
        n_oct      = r_oct;
        n_dots     = r_dots;
        if (!is_comma) begin
            unique case (r_phase)
                PH_START, PH_DIGITS: begin
                    if (r_phase == PH_START && is_blank) begin
                        n_phase = r_phase;
                    end else if (is_digit) begin
                        n_phase    = PH_DIGITS;
                        n_div_seen = 1'b1;
                        if (r_phase == PH_START) begin
                            n_div_acc = DivisorWidth'(digit);
                        end else if (acc_next > {4'd0, {DivisorWidth{1'b1}}}) begin
                            n_div_acc = '1;
                        end else begin
                            n_div_acc = acc_next[DivisorWidth-1:0];
                        end
                    end else if (letter_ok) begin
                        n_note_idx = letter;
                        n_oct      = r_def_oct;
                        n_phase    = PH_NOTE;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_NOTE, PH_SHARP: begin
                    if (r_phase == PH_NOTE && c == 8'd35) begin
                        n_sharp = 1'b1;
                        n_phase = PH_SHARP;
                    end else if (is_digit) begin
                        n_oct   = digit;
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase = PH_TAIL;
                        if (c == 8'd46 && r_dots < DotWidth'(MaxDots)) begin
                            n_dots = r_dots + 1'b1;
                        end
                    end
                end
                PH_TAIL: begin
                    if (c == 8'd46 && r_dots < DotWidth'(MaxDots)) begin
                        n_dots = r_dots + 1'b1;
                    end
                end
                PH_BAD: n_phase = PH_BAD;
                default: n_phase = PH_BAD;
            endcase
        end
    end

    // Note fields decided at the closing character.
    logic bad_letter, oct_bad;
    assign bad_letter = (n_phase == PH_START) || (n_phase == PH_DIGITS) ||
                        (n_phase == PH_BAD);
    assign oct_bad    = (n_oct == 4'd0) || (n_oct > 4'd9) || (n_sharp && n_oct == 4'd9);

    // One division step: shift in the next numerator bit and try a subtract.
    logic [NumWidth:0] rem_shift;
    logic [NumWidth:0] rem_sub;
    assign rem_shift = {r_rem, r_num[NumWidth-1]};
    assign rem_sub   = rem_shift - {{(NumWidth-DenWidth+1){1'b0}}, r_den};

    // The finished note moves to the output register when that is empty or draining.
    assign out_load = (r_seq == S_OUT) && (!r_out_valid || !i_stall);
    assign dur_sat  = r_zero_den ? '0 :
                      (r_quo[QuoWidth-1:DurWidth] != '0) ? '1 :
                      r_quo[DurWidth-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo     <= 10'd120;
            r_def_div   <= 16'd4;
            r_def_oct   <= 4'd4;
            r_phase     <= PH_START;
            r_div_acc   <= '0;
            r_div_seen  <= 1'b0;
            r_note_idx  <= '0;
            r_sharp     <= 1'b0;
            r_oct       <= '0;
            r_dots      <= '0;
            r_seq       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgTempo:   r_tempo   <= i_cfg_data[9:0];
                    CfgDivisor: r_def_div <= i_cfg_data;
                    CfgOctave:  r_def_oct <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (accept_in) begin
                if (emit_now) begin
                    r_phase    <= PH_START;
                    r_div_acc  <= '0;
                    r_div_seen <= 1'b0;
                    r_note_idx <= '0;
                    r_sharp    <= 1'b0;
                    r_oct      <= '0;
                    r_dots     <= '0;
                    r_seq      <= S_MUL;
                end else begin
                    r_phase    <= n_phase;
                    r_div_acc  <= n_div_acc;
                    r_div_seen <= n_div_seen;
                    r_note_idx <= n_note_idx;
                    r_sharp    <= n_sharp;
                    r_oct      <= n_oct;
                    r_dots     <= n_dots;
                end
            end
            unique case (r_seq)
                S_IDLE: ;
                S_MUL:  r_seq <= (r_zero_den) ? S_OUT : S_SCL;
                S_SCL:  if (r_dot_left == '0) r_seq <= S_DIV;
                S_DIV:  if (r_cnt == CntWidth'(NumWidth - 1)) r_seq <= S_OUT;
                S_OUT:  if (out_load) r_seq <= S_IDLE;
                default: r_seq <= S_IDLE;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; the multiplier, scaler and divider share r_num/r_den/r_rem.
    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_div_use  <= n_div_seen ? n_div_acc : r_def_div;
            r_zero_den <= (r_tempo == '0) ||
                          ((n_div_seen ? n_div_acc : r_def_div) == '0);
            r_dot_left <= n_dots;
            r_last     <= i_end_of_text;
            r_oct_out  <= bad_letter ? 4'd0 : n_oct;
            r_freq     <= (bad_letter || oct_bad) ? '0 :
                          note_freq(n_oct, n_note_idx, n_sharp);
            r_status   <= bad_letter ? StBadLetter :
                          ((r_tempo == '0) ||
                           ((n_div_seen ? n_div_acc : r_def_div) == '0)) ? StZeroDiv :
                          oct_bad ? StOctave : StOk;
            r_num      <= BaseNum;
        end
        unique case (r_seq)
            S_MUL: begin
                r_den <= DenWidth'(r_tempo) * DenWidth'(r_div_use);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_SCL: begin
                if (r_dot_left != '0) begin
                    r_num      <= r_num + {r_num[NumWidth-2:0], 1'b0};
                    r_den      <= {r_den[DenWidth-2:0], 1'b0};
                    r_dot_left <= r_dot_left - 1'b1;
                end
            end
            S_DIV: begin
                r_num <= {r_num[NumWidth-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (!rem_sub[NumWidth]) begin
                    r_rem <= rem_sub[NumWidth-1:0];
                    r_quo <= {r_quo[QuoWidth-2:0], 1'b1};
                end else begin
                    r_rem <= rem_shift[NumWidth-1:0];
                    r_quo <= {r_quo[QuoWidth-2:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_freq   <= r_freq;
            r_out_dur    <= dur_sat;
            r_out_oct    <= r_oct_out;
            r_out_status <= r_status;
            r_out_last   <= r_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_freq_centihertz = r_out_freq;
    assign o_duration_us     = r_out_dur;
    assign o_octave_used     = r_out_oct;
    assign o_status          = r_out_status;
    assign o_last_note       = r_out_last;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != S_IDLE) |-> !accept_in) else $error("item taken while busy");
    a_emit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_now |=> (r_seq == S_MUL)) else $error("emit did not start sequencer");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_duration_us)))
        else $error("result changed while stalled");
    a_zero_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == StZeroDiv) |-> (o_duration_us == '0))
        else $error("zero divisor with nonzero duration");

endmodule

/* tb/sv/tb_melody_note_token_parser_core.sv */
// ----------------------------------------------------------------------------
// Melody note token parser core testbench
// Feeds melody text one character per item, through directed rows and then
// random well-formed and broken tokens. Every emitted note is checked against a typed
// expectation or an internal parser model, under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_melody_note_token_parser_core;
    import mntp_pkg::*;

    // Parser phase codes for the internal note model.
    typedef enum int {
        TkStart,
        TkDigits,
        TkNote,
        TkSharp,
        TkTail,
        TkBad
    } t_tok_phase;

    // One emitted note.
    typedef struct packed {
        logic [FreqWidth-1:0] freq;
        logic [DurWidth-1:0]  dur;
        logic [3:0]           oct;
        logic [1:0]           status;
        logic                 last;
    } t_note;

    // One row of the directed table. When known is set and the row closes a
    // note, the expected note is typed in; otherwise the model predicts it.
    typedef struct {
        byte unsigned ch;
        bit           eot;
        bit           known;
        t_note        note;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_char_code;
    logic                 i_end_of_text;
    logic                 o_valid;
    logic                 i_stall;
    logic [FreqWidth-1:0] o_freq_centihertz;
    logic [DurWidth-1:0]  o_duration_us;
    logic [3:0]           o_octave_used;
    logic [1:0]           o_status;
    logic                 o_last_note;

    melody_note_token_parser_core dut (.*);

    // Shadow copy of the configuration registers.
    logic [9:0]  bpm_q;
    logic [15:0] defdiv_q;
    logic [3:0]  defoct_q;

    // Shadow copy of the token in progress.
    t_tok_phase  tok_phase;
    logic [16:0] tok_div;
    bit          tok_div_seen;
    int          tok_idx;
    bit          tok_sharp;
    logic [3:0]  tok_oct;
    int          tok_dots;

    t_note pending_notes[$];
    int    error_count;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    bit    hold_receiver;
    int    quiet_cycles;
    int    sent_items;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_token();
        tok_phase    = TkStart;
        tok_div      = '0;
        tok_div_seen = 0;
        tok_idx      = 0;
        tok_sharp    = 0;
        tok_oct      = '0;
        tok_dots     = 0;
    endfunction

    function automatic int letter_of(byte unsigned c);
        case (c)
            "C": return 0;
            "D": return 1;
            "E": return 2;
            "F": return 3;
            "G": return 4;
            "A": return 5;
            "B": return 6;
            default: return -1;
        endcase
    endfunction

    function automatic void take_letter(byte unsigned c);
        int n;
        n = letter_of(c);
        if (n < 0) begin
            tok_phase = TkBad;
        end else begin
            tok_idx   = n;
            tok_oct   = defoct_q;
            tok_phase = TkNote;
        end
    endfunction

    function automatic void take_tail(byte unsigned c);
        tok_phase = TkTail;
        if (c == "." && tok_dots < MaxDots) tok_dots++;
    endfunction

    function automatic bit is_digit(byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    // Frequency table in centihertz, written out independently of the package.
    function automatic int freq_of(int oct, int idx, bit sharp);
        int nat[63];
        int shp[56];
        nat = '{3270, 3671, 4120, 4365, 4900, 5500, 6174,
                6541, 7342, 8241, 8731, 9800, 11000, 12347,
                13081, 14683, 16481, 17461, 19600, 22000, 24694,
                26163, 29366, 32963, 34923, 39200, 44000, 49388,
                52325, 58733, 65925, 69846, 78399, 88000, 98777,
                104650, 117466, 131851, 139691, 156798, 176000, 197553,
                209300, 234932, 263702, 279383, 313596, 352000, 395107,
                418601, 469863, 527404, 558765, 627193, 704000, 790213,
                837202, 939727, 1054808, 1117530, 1254385, 1408000, 1580427};
        shp = '{3465, 3889, 4365, 4625, 5191, 5827, 6541,
                6930, 7778, 8731, 9250, 10383, 11654, 13081,
                13859, 15556, 17461, 18500, 20765, 23308, 26163,
                27718, 31113, 34923, 36999, 41530, 46616, 52325,
                55437, 62225, 69846, 73999, 83061, 93233, 104650,
                110873, 124451, 139691, 147998, 166122, 186466, 209300,
                221746, 248902, 279383, 295996, 332244, 372931, 418601,
                443492, 497803, 558765, 591991, 664488, 745862, 837202};
        return sharp ? shp[(oct - 1) * 7 + idx] : nat[(oct - 1) * 7 + idx];
    endfunction

    function automatic t_note close_token(bit last);
        t_note n;
        logic [15:0] dv;
        logic [63:0] num, den, dur;
        bit bad, zero, obad;
        n    = '0;
        dv   = tok_div_seen ? tok_div[15:0] : defdiv_q;
        num  = 64'd240000000;
        den  = 64'(bpm_q) * 64'(dv);
        zero = den == 0;
        if (!zero) begin
            for (int i = 0; i < tok_dots; i++) begin
                num = num * 3;
                den = den * 2;
            end
            dur   = num / den;
            n.dur = dur > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : dur[31:0];
        end
        bad = tok_phase inside {TkStart, TkDigits, TkBad};
        if (bad) begin
            n.status = StBadLetter;
        end else begin
            n.oct = tok_oct;
            obad  = tok_oct == 0 || tok_oct > 9 || (tok_sharp && tok_oct == 9);
            if (!obad) n.freq = FreqWidth'(freq_of(tok_oct, tok_idx, tok_sharp));
            if (zero) n.status = StZeroDiv;
            else if (obad) n.status = StOctave;
            else n.status = StOk;
        end
        n.last = last;
        return n;
    endfunction

    // Advance the token model by one character; returns 1 with a note when one closes.
    function automatic bit parse_char(byte unsigned c, bit eot, output t_note n);
        n = '0;
        if (c != ",") begin
            case (tok_phase)
                TkStart: begin
                    if (c == 32 || (c >= 9 && c <= 13)) begin
                    end else if (is_digit(c)) begin
                        tok_phase    = TkDigits;
                        tok_div_seen = 1;
                        tok_div      = 17'(c - "0");
                    end else begin
                        take_letter(c);
                    end
                end
                TkDigits: begin
                    if (is_digit(c)) begin
                        if (tok_div > 6553) tok_div = 17'hFFFF;
                        else tok_div = tok_div * 10 + 17'(c - "0");
                        if (tok_div > 17'hFFFF) tok_div = 17'hFFFF;
                    end else begin
                        take_letter(c);
                    end
                end
                TkNote, TkSharp: begin
                    if (tok_phase == TkNote && c == "#") begin
                        tok_sharp = 1;
                        tok_phase = TkSharp;
                    end else if (is_digit(c)) begin
                        tok_oct   = 4'(c - "0");
                        tok_phase = TkTail;
                    end else begin
                        take_tail(c);
                    end
                end
                TkTail: take_tail(c);
                default: ;
            endcase
        end
        if (c == "," || eot) begin
            n = close_token(eot);
            clear_token();
            return 1;
        end
        return 0;
    endfunction

    // Offer one character and wait until it is accepted; record a typed or predicted note.
    // Valid stays high after acceptance; the next caller drives it again or drops it.
    task automatic send_char(byte unsigned c, bit eot, bit known, t_note typed);
        t_note n;
        while (($urandom_range(99) < sender_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_char_code   <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_items++;
        if (parse_char(c, eot, n)) pending_notes = {pending_notes, (known ? typed : n)};
    endtask

    task automatic send_text(string s, bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot_at_end && i == s.len() - 1, 0, '0);
    endtask

    // Registers change only with nothing in flight; wait out the divider too.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_valid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgTempo:   bpm_q    = val[9:0];
            CfgDivisor: defdiv_q = val;
            CfgOctave:  defoct_q = val[3:0];
            default: ;
        endcase
    endtask

    function automatic byte unsigned pick_letter();
        byte unsigned l[7];
        l = '{"C", "D", "E", "F", "G", "A", "B"};
        return l[$urandom_range(6)];
    endfunction

    // One random token: mostly well formed, some noise, ending in a comma or end of text.
    task automatic random_token(bit final_token);
        string s;
        int k;
        s = "";
        if ($urandom_range(9) == 0) begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) s = {s, string'(byte'($urandom_range(255)))};
        end else begin
            if ($urandom_range(3) == 0) s = {s, " "};
            if ($urandom_range(1)) begin
                k = $urandom_range(1, $urandom_range(7) == 0 ? 7 : 2);
                for (int i = 0; i < k; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
            end
            s = {s, string'(pick_letter())};
            if ($urandom_range(2) == 0) s = {s, "#"};
            if ($urandom_range(1)) s = {s, string'(byte'("0" + $urandom_range(9)))};
            k = $urandom_range(3) == 0 ? $urandom_range(9) : 0;
            for (int i = 0; i < k; i++) s = {s, "."};
            if ($urandom_range(7) == 0) s = {s, string'(byte'($urandom_range(255)))};
        end
        // Commas inside the random noise would just close tokens early; that is fine.
        if (final_token && $urandom_range(1)) begin
            send_text(s, 0);
            send_char(",", 1, 0, '0);
        end else if (final_token) begin
            if (s.len() == 0) s = "A";
            send_text(s, 1);
        end else begin
            send_text({s, ","}, 0);
        end
    endtask

    // Receiver: random stalls by percentage, or a long hold when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= hold_receiver || ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Compare every accepted note with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_notes.size() == 0) begin
                $error("note with nothing expected");
                error_count++;
            end else begin
                t_note e;
                e = pending_notes.pop_front();
                if (o_freq_centihertz !== e.freq) begin
                    $error("freq_centihertz exp %0d got %0d", e.freq, o_freq_centihertz);
                    error_count++;
                end
                if (o_duration_us !== e.dur) begin
                    $error("duration_us exp %0d got %0d", e.dur, o_duration_us);
                    error_count++;
                end
                if (o_octave_used !== e.oct) begin
                    $error("octave_used exp %0d got %0d", e.oct, o_octave_used);
                    error_count++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    error_count++;
                end
                if (o_last_note !== e.last) begin
                    $error("last_note exp %0d got %0d", e.last, o_last_note);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any cycle with a handshake on either side resets the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Directed rows. Typed notes hold at the reset settings: 120 bpm, divisor 4, octave 4.
    t_row rows[$];

    function automatic t_note mk(int f, longint d, int o, logic [1:0] s, bit l);
        t_note n;
        n.freq = FreqWidth'(f);
        n.dur = DurWidth'(d);
        n.oct = 4'(o);
        n.status = s;
        n.last = l;
        return n;
    endfunction

    function automatic void row(byte unsigned c, bit eot = 0, bit known = 0, t_note n = '0);
        t_row r;
        r.ch = c;
        r.eot = eot;
        r.known = known;
        r.note = n;
        rows = {rows, r};
    endfunction

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CfgTempo;
        i_cfg_data         = '0;
        i_valid            = 1'b0;
        i_char_code        = '0;
        i_end_of_text      = 1'b0;
        hold_receiver      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        quiet_cycles       = 0;
        sent_items         = 0;
        bpm_q              = 10'd120;
        defdiv_q           = 16'd4;
        defoct_q           = 4'd4;
        clear_token();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // "A," at reset: A4 quarter note, 500 ms.
        row("A"); row(",", 0, 1, mk(44000, 500000, 4, StOk, 0));
        // Empty token is a bad letter.
        row(",", 0, 1, mk(0, 500000, 0, StBadLetter, 0));
        // Zero duration digits.
        row("0"); row("C"); row(",", 0, 1, mk(26163, 0, 4, StZeroDiv, 0));
        // Sharp octave nine is outside the table.
        row(" "); row("B"); row("#"); row("9");
        row(",", 0, 1, mk(0, 500000, 9, StOctave, 0));
        // Octave zero, the highest natural note with dots, a bad letter and end of text.
        row("C"); row("0"); row(",", 0, 1, mk(0, 500000, 0, StOctave, 0));
        row("B"); row("9"); row(".", 0); row(".", 0); row(",");
        row("X"); row("A", 1);
        row("1"); row("G"); row(",", 1);
        foreach (rows[i]) send_char(rows[i].ch, rows[i].eot, rows[i].known, rows[i].note);

        // Register extremes.
        write_reg(CfgTempo, 16'd1);
        write_reg(CfgDivisor, 16'd1);
        write_reg(CfgOctave, 16'd9);
        send_text("A#...........,C,B,", 0);
        write_reg(CfgTempo, 16'd1000);
        write_reg(CfgDivisor, 16'hFFFF);
        write_reg(CfgOctave, 16'd1);
        send_text("\tG#.......,99999999D3,F", 1);
        write_reg(CfgDivisor, 16'd0);
        write_reg(CfgOctave, 16'd15);
        send_text("E,12A#.,q", 1);
        write_reg(CfgTempo, 16'd0);
        send_text("16C5", 1);

        // Random phases with different idling and settings.
        for (int ph = 0; ph < 5; ph++) begin
            int items;
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                3: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            write_reg(CfgTempo, 16'($urandom_range(1, 1000)));
            write_reg(CfgDivisor, $urandom_range(5) == 0 ? 16'($urandom) :
                                  16'($urandom_range(1, 32)));
            write_reg(CfgOctave, 16'($urandom_range(ph == 4 ? 0 : 1, ph == 4 ? 15 : 9)));
            if (ph == 4) begin
                // Long receiver hold while characters keep coming.
                hold_receiver = 1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_receiver = 0;
                    end
                join_none
            end
            items = sent_items + 195;
            while (sent_items < items) begin
                int tokens;
                tokens = $urandom_range(1, 6);
                for (int t = 0; t < tokens; t++) random_token(t == tokens - 1);
            end
        end

        i_valid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
